FILE: src/ept_pkg.sv
// shared types, constants and tables of the euler pose point transform
`timescale 1ns / 1ps
`default_nettype none
package ept_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CoordW = 32;
  localparam int unsigned AngleW = 16;
  localparam int unsigned TrigW = 32;
  localparam int unsigned CordW = 34;
  localparam int unsigned NumSteps = 14;

  localparam logic [CfgIdxW-1:0] REG_OFFSET_X = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_Z = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_YAW = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PITCH = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ROLL = 3'd5;

  localparam logic signed [CordW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CordW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [CordW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam logic [31:0] ATAN_Q30 [31] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536,
    32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048,
    32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
    32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1
  };

  typedef enum logic [2:0] {
    RB_IDLE,
    RB_WAIT,
    RB_MUL,
    RB_ACC,
    RB_DONE
  } rb_state_e;

  typedef enum logic [2:0] {
    OP_SY,
    OP_CY,
    OP_SP,
    OP_CP,
    OP_SR,
    OP_CR,
    OP_T
  } mul_op_e;

  typedef enum logic [2:0] {
    ACT_T,
    ACT_A,
    ACT_SET,
    ACT_ADD,
    ACT_SUB
  } acc_act_e;

  typedef struct packed {
    mul_op_e    op_a;
    mul_op_e    op_b;
    acc_act_e   act;
    logic [3:0] idx;
  } step_ctl_t;

  typedef struct packed {
    logic busy;
  } rb_status_t;

  function automatic step_ctl_t step_ctl(input logic [3:0] step);
    step_ctl_t c;
    c = '{op_a: OP_CY, op_b: OP_CP, act: ACT_SET, idx: 4'd0};
    unique case (step)
      4'd0:  c = '{op_a: OP_CY, op_b: OP_CP, act: ACT_SET, idx: 4'd0};
      4'd1:  c = '{op_a: OP_CY, op_b: OP_SP, act: ACT_T,   idx: 4'd0};
      4'd2:  c = '{op_a: OP_T,  op_b: OP_SR, act: ACT_A,   idx: 4'd0};
      4'd3:  c = '{op_a: OP_CR, op_b: OP_SY, act: ACT_SUB, idx: 4'd1};
      4'd4:  c = '{op_a: OP_SY, op_b: OP_SR, act: ACT_A,   idx: 4'd0};
      4'd5:  c = '{op_a: OP_T,  op_b: OP_CR, act: ACT_ADD, idx: 4'd2};
      4'd6:  c = '{op_a: OP_CP, op_b: OP_SY, act: ACT_SET, idx: 4'd3};
      4'd7:  c = '{op_a: OP_SY, op_b: OP_SP, act: ACT_T,   idx: 4'd0};
      4'd8:  c = '{op_a: OP_CY, op_b: OP_CR, act: ACT_A,   idx: 4'd0};
      4'd9:  c = '{op_a: OP_T,  op_b: OP_SR, act: ACT_ADD, idx: 4'd4};
      4'd10: c = '{op_a: OP_T,  op_b: OP_CR, act: ACT_A,   idx: 4'd0};
      4'd11: c = '{op_a: OP_CY, op_b: OP_SR, act: ACT_SUB, idx: 4'd5};
      4'd12: c = '{op_a: OP_CP, op_b: OP_SR, act: ACT_SET, idx: 4'd7};
      4'd13: c = '{op_a: OP_CR, op_b: OP_CP, act: ACT_SET, idx: 4'd8};
      default: c = '{op_a: OP_CY, op_b: OP_CP, act: ACT_SET, idx: 4'd0};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: src/ept_cordic.sv
// iterative cordic sine and cosine, one rotation step per cycle
`timescale 1ns / 1ps
`default_nettype none
module ept_cordic import ept_pkg::*; #(
  parameter int unsigned CordicSteps = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [AngleW-1:0] angle_i,
  output logic                          done_o,
  output logic signed [TrigW-1:0]       sin_o,
  output logic signed [TrigW-1:0]       cos_o
);

  localparam int unsigned CntW = $clog2(CordicSteps + 1);

  logic                    run_q;
  logic [CntW-1:0]         cnt_q;
  logic                    neg_q;
  logic signed [CordW-1:0] x_q, y_q, z_q;
  logic signed [CordW-1:0] z0, dx, dy, at;
  logic                    last;

  assign z0 = {angle_i[AngleW-1], angle_i, 17'b0};
  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;
  assign at = CordW'(ATAN_Q30[5'(cnt_q)]);
  assign last = (cnt_q == CntW'(CordicSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= run_q && last;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= CORDIC_GAIN;
      y_q <= '0;
      if (z0 > HALF_PI_Q30) begin
        z_q   <= z0 - PI_Q30;
        neg_q <= 1'b1;
      end else if (z0 < -HALF_PI_Q30) begin
        z_q   <= z0 + PI_Q30;
        neg_q <= 1'b1;
      end else begin
        z_q   <= z0;
        neg_q <= 1'b0;
      end
    end else if (run_q) begin
      if (!z_q[CordW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  always_comb begin
    logic signed [CordW-1:0] c, s;
    c = neg_q ? -x_q : x_q;
    s = neg_q ? -y_q : y_q;
    cos_o = c[TrigW-1:0];
    sin_o = s[TrigW-1:0];
  end

endmodule
`default_nettype wire

FILE: src/ept_rot_build.sv
// rotation matrix builder: cordic per angle, then a shared multiplier sequence
`timescale 1ns / 1ps
`default_nettype none
module ept_rot_build import ept_pkg::*; #(
  parameter int unsigned CoeffFracBits = 16,
  parameter int unsigned CordicSteps = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     rebuild_i,
  input  wire logic signed [AngleW-1:0] yaw_i,
  input  wire logic signed [AngleW-1:0] pitch_i,
  input  wire logic signed [AngleW-1:0] roll_i,
  output rb_status_t                    status_o,
  output logic [8:0][CoeffFracBits+1:0] coeff_o
);

  localparam int unsigned CoefW = CoeffFracBits + 2;
  localparam int unsigned Sh = 30 - CoeffFracBits;
  localparam logic signed [CordW:0] Rnd = (Sh == 0) ? '0 :
    ((CordW+1)'(1) <<< ((Sh > 0) ? Sh - 1 : 0));
  localparam logic signed [CordW:0] Lim = (CordW+1)'(1) <<< (CoeffFracBits + 1);

  rb_state_e state_q, state_d;
  logic      pending_q;
  logic [1:0] sel_q, sel_d;
  logic [3:0] step_q, step_d;
  logic       cor_start, cor_done;
  logic signed [AngleW-1:0] cor_angle;
  logic signed [TrigW-1:0]  cor_sin, cor_cos;
  logic signed [TrigW-1:0]  sy_q, cy_q, sp_q, cp_q, sr_q, cr_q, t_q, a_q;
  logic signed [63:0]       prod_q, rsum;
  logic signed [CordW-1:0]  r34;
  step_ctl_t                ctl;

  function automatic logic [CoefW-1:0] to_coeff(input logic signed [CordW-1:0] v);
    logic signed [CordW:0] r;
    r = ($signed({v[CordW-1], v}) + Rnd) >>> Sh;
    if (r > Lim - 1) r = Lim - 1;
    else if (r < -Lim) r = -Lim;
    return r[CoefW-1:0];
  endfunction

  function automatic logic signed [TrigW-1:0] pick(input mul_op_e op,
      input logic signed [TrigW-1:0] sy, cy, sp, cp, sr, cr, t);
    logic signed [TrigW-1:0] v;
    v = t;
    unique case (op)
      OP_SY:   v = sy;
      OP_CY:   v = cy;
      OP_SP:   v = sp;
      OP_CP:   v = cp;
      OP_SR:   v = sr;
      OP_CR:   v = cr;
      OP_T:    v = t;
      default: v = t;
    endcase
    return v;
  endfunction

  ept_cordic #(.CordicSteps(CordicSteps)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .done_o  (cor_done),
    .sin_o   (cor_sin),
    .cos_o   (cor_cos)
  );

  assign ctl = step_ctl(step_q);
  assign rsum = (prod_q + 64'sd536870912) >>> 30;
  assign r34 = rsum[CordW-1:0];
  assign status_o.busy = pending_q || (state_q != RB_IDLE);

  always_comb begin
    unique case (sel_d)
      2'd0:    cor_angle = yaw_i;
      2'd1:    cor_angle = pitch_i;
      default: cor_angle = roll_i;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    sel_d     = sel_q;
    step_d    = step_q;
    cor_start = 1'b0;
    unique case (state_q)
      RB_IDLE: begin
        if (pending_q) begin
          sel_d     = 2'd0;
          cor_start = 1'b1;
          state_d   = RB_WAIT;
        end
      end
      RB_WAIT: begin
        if (cor_done) begin
          if (sel_q == 2'd2) begin
            step_d  = '0;
            state_d = RB_MUL;
          end else begin
            sel_d     = sel_q + 2'd1;
            cor_start = 1'b1;
          end
        end
      end
      RB_MUL: state_d = RB_ACC;
      RB_ACC: begin
        if (step_q == 4'(NumSteps - 1)) begin
          state_d = RB_DONE;
        end else begin
          step_d  = step_q + 4'd1;
          state_d = RB_MUL;
        end
      end
      RB_DONE: state_d = RB_IDLE;
      default: state_d = RB_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= RB_IDLE;
      pending_q <= 1'b1;
      sel_q     <= '0;
      step_q    <= '0;
      coeff_o   <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      step_q  <= step_d;
      if (rebuild_i) pending_q <= 1'b1;
      else if (state_q == RB_IDLE) pending_q <= 1'b0;
      if (state_q == RB_ACC) begin
        unique case (ctl.act)
          ACT_SET: coeff_o[ctl.idx] <= to_coeff(r34);
          ACT_ADD: coeff_o[ctl.idx] <= to_coeff(CordW'(a_q) + r34);
          ACT_SUB: coeff_o[ctl.idx] <= to_coeff(CordW'(a_q) - r34);
          default: ;
        endcase
      end else if (state_q == RB_DONE) begin
        coeff_o[6] <= to_coeff(-CordW'(sp_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == RB_WAIT && cor_done) begin
      unique case (sel_q)
        2'd0: begin
          sy_q <= cor_sin;
          cy_q <= cor_cos;
        end
        2'd1: begin
          sp_q <= cor_sin;
          cp_q <= cor_cos;
        end
        default: begin
          sr_q <= cor_sin;
          cr_q <= cor_cos;
        end
      endcase
    end
    if (state_q == RB_MUL) begin
      prod_q <= pick(ctl.op_a, sy_q, cy_q, sp_q, cp_q, sr_q, cr_q, t_q)
              * pick(ctl.op_b, sy_q, cy_q, sp_q, cp_q, sr_q, cr_q, t_q);
    end
    if (state_q == RB_ACC) begin
      if (ctl.act == ACT_T) t_q <= r34[TrigW-1:0];
      if (ctl.act == ACT_A) a_q <= r34[TrigW-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: src/ept_xform_pipe.sv
// three stage point pipeline: products, rounded row sums, offset and saturate
`timescale 1ns / 1ps
`default_nettype none
module ept_xform_pipe import ept_pkg::*; #(
  parameter int unsigned CoeffFracBits = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        fire_i,
  output logic                             ready_o,
  input  wire logic signed [CoordW-1:0]    pt_x_i,
  input  wire logic signed [CoordW-1:0]    pt_y_i,
  input  wire logic signed [CoordW-1:0]    pt_z_i,
  input  wire logic [8:0][CoeffFracBits+1:0] coeff_i,
  input  wire logic [2:0][CoordW-1:0]      offset_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic signed [CoordW-1:0]         out_x_o,
  output logic signed [CoordW-1:0]         out_y_o,
  output logic signed [CoordW-1:0]         out_z_o
);

  localparam int unsigned CoefW = CoeffFracBits + 2;
  localparam int unsigned AccW = 66;
  localparam logic signed [AccW-1:0] Rnd = AccW'(1) <<< (CoeffFracBits - 1);
  localparam logic signed [AccW:0] SatHi = 67'sd2147483647;
  localparam logic signed [AccW:0] SatLo = -67'sd2147483648;

  logic v1_q, v2_q;
  logic rdy1, rdy2, rdy3;
  logic signed [63:0] prod_q [9];
  logic signed [AccW-1:0] acc_q [3];
  logic signed [CoordW-1:0] pt [3];
  logic signed [CoordW-1:0] res [3];

  assign pt[0] = pt_x_i;
  assign pt[1] = pt_y_i;
  assign pt[2] = pt_z_i;

  assign rdy3 = !out_valid_o || !out_stall_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (rdy1) v1_q <= fire_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) out_valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && fire_i) begin
      for (int k = 0; k < 9; k++) begin
        prod_q[k] <= $signed(CoordW'($signed(coeff_i[k][CoefW-1:0]))) * pt[k % 3];
      end
    end
    if (rdy2 && v1_q) begin
      for (int r = 0; r < 3; r++) begin
        acc_q[r] <= AccW'(prod_q[3*r]) + AccW'(prod_q[3*r+1])
                  + AccW'(prod_q[3*r+2]) + Rnd;
      end
    end
    if (rdy3 && v2_q) begin
      out_x_o <= res[0];
      out_y_o <= res[1];
      out_z_o <= res[2];
    end
  end

  always_comb begin
    logic signed [AccW:0] s;
    for (int r = 0; r < 3; r++) begin
      s = (AccW+1)'(acc_q[r] >>> CoeffFracBits)
        + (AccW+1)'($signed(offset_i[r]));
      if (s > SatHi) res[r] = 32'sh7fffffff;
      else if (s < SatLo) res[r] = 32'sh80000000;
      else res[r] = s[CoordW-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: src/euler_pose_point_transform_core.sv
// top level: pose registers, matrix builder and point pipeline
`timescale 1ns / 1ps
`default_nettype none
// Maps sensor-frame points to the vehicle frame as R*p + offset, with
// R = Rz(yaw)*Ry(pitch)*Rx(roll). After reset and after every write to an
// offset or angle register the block rebuilds R: one cordic run per angle,
// then 14 multiply steps on one shared multiplier, during which in_stall_o
// is held high. Once built, the point pipeline takes one point per clock
// while no stall backs it up, and results pass through the product,
// row-sum and output registers; out_stall_i backs up the three stages
// without losing points.
module euler_pose_point_transform_core import ept_pkg::*; #(
  parameter int unsigned COEFF_FRAC_BITS = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [CfgDataW-1:0]      cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [CoordW-1:0] pt_x_i,
  input  wire logic signed [CoordW-1:0] pt_y_i,
  input  wire logic signed [CoordW-1:0] pt_z_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [CoordW-1:0]      out_x_o,
  output logic signed [CoordW-1:0]      out_y_o,
  output logic signed [CoordW-1:0]      out_z_o
);

  logic [2:0][CoordW-1:0]          offset_q;
  logic signed [AngleW-1:0]        yaw_q, pitch_q, roll_q;
  logic                            cfg_hit, pipe_ready, fire;
  rb_status_t                      rb_status;
  logic [8:0][COEFF_FRAC_BITS+1:0] coeff;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z, REG_YAW, REG_PITCH, REG_ROLL:
          cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      yaw_q    <= '0;
      pitch_q  <= '0;
      roll_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OFFSET_X: offset_q[0] <= cfg_data_i;
        REG_OFFSET_Y: offset_q[1] <= cfg_data_i;
        REG_OFFSET_Z: offset_q[2] <= cfg_data_i;
        REG_YAW:      yaw_q <= cfg_data_i[AngleW-1:0];
        REG_PITCH:    pitch_q <= cfg_data_i[AngleW-1:0];
        REG_ROLL:     roll_q <= cfg_data_i[AngleW-1:0];
        default: ;
      endcase
    end
  end

  ept_rot_build #(
    .CoeffFracBits (COEFF_FRAC_BITS),
    .CordicSteps   (CORDIC_STEPS)
  ) u_rot_build (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rebuild_i (cfg_hit),
    .yaw_i     (yaw_q),
    .pitch_i   (pitch_q),
    .roll_i    (roll_q),
    .status_o  (rb_status),
    .coeff_o   (coeff)
  );

  assign in_stall_o = rb_status.busy || !pipe_ready;
  assign fire = in_valid_i && !in_stall_o;

  ept_xform_pipe #(
    .CoeffFracBits (COEFF_FRAC_BITS)
  ) u_xform_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .ready_o     (pipe_ready),
    .pt_x_i      (pt_x_i),
    .pt_y_i      (pt_y_i),
    .pt_z_i      (pt_z_i),
    .coeff_i     (coeff),
    .offset_i    (offset_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o)
  );

endmodule
`default_nettype wire

FILE: dv/tb.sv
// testbench of the euler pose point transform core with a scoreboard and predictor
`timescale 1ns / 1ps
module tb;
  import ept_pkg::*;

  localparam int unsigned FracBits = 16;
  localparam int unsigned Steps = 16;
  localparam int unsigned IdleLimit = 4000;
  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 3'd7;
  localparam logic signed [31:0] CoordMax = 32'sh7fffffff;
  localparam logic signed [31:0] CoordMin = 32'sh80000000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } coord_t;

  class frame_map_board;
    logic [31:0] offset [3];
    logic [15:0] angle [3];
    longint rot [9];
    bit stale;
    coord_t vehicle_pts [$];
    int errors;

    function new();
      for (int k = 0; k < 3; k++) begin
        offset[k] = '0;
        angle[k] = '0;
      end
      for (int k = 0; k < 9; k++) rot[k] = (k % 4 == 0) ? (64'sd1 <<< FracBits) : 0;
      stale = 1;
      errors = 0;
    endfunction

    function longint rnd_shift(longint v, int unsigned s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint mul_q30(longint a, longint b);
      return rnd_shift(a * b, 30);
    endfunction

    function longint coeff_of(longint v);
      longint lim;
      lim = 64'sd1 <<< (FracBits + 1);
      return clamp(rnd_shift(v, 30 - FracBits), -lim, lim - 1);
    endfunction

    function void sin_cos(input logic signed [15:0] a, output longint s, output longint c);
      longint z, x, y, dx, dy;
      bit flip;
      z = longint'(a) * 131072;
      x = longint'(CORDIC_GAIN);
      y = 0;
      flip = 0;
      if (z > longint'(HALF_PI_Q30)) begin
        z -= longint'(PI_Q30);
        flip = 1;
      end else if (z < -longint'(HALF_PI_Q30)) begin
        z += longint'(PI_Q30);
        flip = 1;
      end
      for (int i = 0; i < Steps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= longint'(ATAN_Q30[i]);
        end else begin
          x += dx;
          y -= dy;
          z += longint'(ATAN_Q30[i]);
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void build_rotation();
      longint sy, cy, sp, cp, sr, cr, t;
      sin_cos(angle[0], sy, cy);
      sin_cos(angle[1], sp, cp);
      sin_cos(angle[2], sr, cr);
      rot[0] = coeff_of(mul_q30(cy, cp));
      t = mul_q30(cy, sp);
      rot[1] = coeff_of(mul_q30(t, sr) - mul_q30(cr, sy));
      rot[2] = coeff_of(mul_q30(sy, sr) + mul_q30(t, cr));
      rot[3] = coeff_of(mul_q30(cp, sy));
      t = mul_q30(sy, sp);
      rot[4] = coeff_of(mul_q30(cy, cr) + mul_q30(t, sr));
      rot[5] = coeff_of(mul_q30(t, cr) - mul_q30(cy, sr));
      rot[6] = coeff_of(-sp);
      rot[7] = coeff_of(mul_q30(cp, sr));
      rot[8] = coeff_of(mul_q30(cr, cp));
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
      if (idx > REG_ROLL) return;
      if (idx <= REG_OFFSET_Z) offset[idx] = data;
      else angle[idx - REG_YAW] = data[15:0];
      stale = 1;
    endfunction

    function void note_point(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz);
      longint acc, v [3];
      coord_t e;
      if (stale) begin
        build_rotation();
        stale = 0;
      end
      for (int r = 0; r < 3; r++) begin
        acc = rot[r*3] * longint'(px) + rot[r*3+1] * longint'(py) + rot[r*3+2] * longint'(pz);
        v[r] = clamp(rnd_shift(acc, FracBits) + longint'($signed(offset[r])),
                     -64'sd2147483648, 64'sd2147483647);
      end
      e.x = v[0][31:0];
      e.y = v[1][31:0];
      e.z = v[2][31:0];
      vehicle_pts.push_back(e);
    endfunction

    function void check_result(logic signed [31:0] ox, logic signed [31:0] oy,
                               logic signed [31:0] oz);
      coord_t e;
      if (vehicle_pts.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time, ox, oy, oz);
        errors++;
        return;
      end
      e = vehicle_pts.pop_front();
      if (ox !== e.x) begin
        $display("%0t: out_x expected %0d actual %0d", $time, e.x, ox);
        errors++;
      end
      if (oy !== e.y) begin
        $display("%0t: out_y expected %0d actual %0d", $time, e.y, oy);
        errors++;
      end
      if (oz !== e.z) begin
        $display("%0t: out_z expected %0d actual %0d", $time, e.z, oz);
        errors++;
      end
    endfunction

    function int pending();
      return vehicle_pts.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [CoordW-1:0] pt_x_i, pt_y_i, pt_z_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [CoordW-1:0] out_x_o, out_y_o, out_z_o;

  frame_map_board board;
  bit calm;
  int unsigned quiet_cycles;

  euler_pose_point_transform_core #(
    .COEFF_FRAC_BITS(FracBits),
    .CORDIC_STEPS(Steps)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .pt_x_i(pt_x_i),
    .pt_y_i(pt_y_i),
    .pt_z_i(pt_z_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_x_o(out_x_o),
    .out_y_o(out_y_o),
    .out_z_o(out_z_o)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    out_stall_i = 0;
    forever begin
      @(negedge clk_i);
      out_stall_i = !calm && ($urandom_range(0, 99) < 24);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(out_x_o, out_y_o, out_z_o);
      quiet_cycles = 0;
    end
  end

  always @(posedge clk_i) begin
    quiet_cycles++;
    if (quiet_cycles > IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_we_i = 1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    board.write_reg(idx, data);
    quiet_cycles = 0;
    @(negedge clk_i);
    cfg_we_i = 0;
  endtask

  task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z);
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_valid_i = 0;
      @(negedge clk_i);
    end
    in_valid_i = 1;
    pt_x_i = x;
    pt_y_i = y;
    pt_z_i = z;
    do @(posedge clk_i); while (in_stall_o);
    board.note_point(x, y, z);
    quiet_cycles = 0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_pose(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                          input logic [31:0] yaw, input logic [31:0] pitch,
                          input logic [31:0] roll);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_Z, oz);
    write_reg(REG_YAW, yaw);
    write_reg(REG_PITCH, pitch);
    write_reg(REG_ROLL, roll);
  endtask

  function automatic logic [31:0] rand_angle();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(0, 3) != 0) a[15:0] = 16'($urandom_range(0, 51472) - 25736);
    return a;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
      2: return $urandom_range(0, 1) ? CoordMax : CoordMin;
      default: return 32'($urandom_range(0, 1 << 26)) - 32'd33554432;
    endcase
  endfunction

  initial begin
    logic signed [31:0] edge_vals [6];
    board = new();
    calm = 0;
    quiet_cycles = 0;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 0;
    pt_x_i = '0;
    pt_y_i = '0;
    pt_z_i = '0;
    edge_vals = '{CoordMax, CoordMin, 32'sd0, -32'sd1, 32'sd1, 32'sh00010000};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // reset pose
    for (int i = 0; i < 6; i++) send_point(edge_vals[i], edge_vals[(i+1)%6], edge_vals[(i+3)%6]);
    drain();

    // extreme poses, the first two with saturating offsets, and spare register writes
    set_pose(CoordMax, CoordMax, CoordMax, 32'hffff6488, 32'h00006488, 32'hdead6488);
    for (int i = 0; i < 5; i++) send_point(edge_vals[i], edge_vals[(i+2)%6], edge_vals[(i+4)%6]);
    drain();
    set_pose(CoordMin, CoordMin, CoordMin, 32'h00007fff, 32'h00008000, 32'h00003244);
    for (int i = 0; i < 5; i++) send_point(edge_vals[(i+1)%6], edge_vals[i], edge_vals[(i+5)%6]);
    drain();
    set_pose(32'h0, 32'hffffffff, 32'h1, 32'h0000ffff, 32'h00003245, 32'h0000cdbb);
    write_reg(REG_SPARE_A, 32'h7fff0000);
    write_reg(REG_SPARE_B, 32'hffffffff);
    for (int i = 0; i < 6; i++) send_point(edge_vals[i], edge_vals[i], edge_vals[i]);
    drain();

    // random poses and points
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 3);
      for (int r = 0; r <= REG_ROLL; r++) begin
        if ($urandom_range(0, 3) != 0)
          write_reg(r[CfgIdxW-1:0], (r <= REG_OFFSET_Z) ? rand_coord() : rand_angle());
      end
      if ($urandom_range(0, 1)) write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
      for (int i = 0; i < 100; i++) send_point(rand_coord(), rand_coord(), rand_coord());
      drain();
    end
    calm = 0;

    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

FILE: files.f
src/ept_pkg.sv
src/ept_cordic.sv
src/ept_rot_build.sv
src/ept_xform_pipe.sv
src/euler_pose_point_transform_core.sv
dv/tb.sv
